@@ rtl/core/centered_window_average_top_defines.svh @@
// ---------------------------------------------------------------------------
// Centered window average - assertion macros
// Shared concurrent assertion forms for the block's checks.
// ---------------------------------------------------------------------------
`ifndef CENTERED_WINDOW_AVERAGE_TOP_DEFINES_SVH
`define CENTERED_WINDOW_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define CWA_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define CWA_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/cwa_pkg.sv @@
// ---------------------------------------------------------------------------
// cwa_pkg
// Fixed field widths and codes of the centered window average block.
// ---------------------------------------------------------------------------
`default_nettype none

package cwa_pkg;

   localparam int SAMPLE_W = 16;   // sample field
   localparam int AVG_W    = 17;   // average field, two's complement
   localparam int RADIUS_W = 6;    // radius register

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd1;
   localparam logic [AVG_W-1:0]    AVG_NONE     = {AVG_W{1'b1}};  // -1: window does not fit

endpackage

`default_nettype wire

@@ rtl/core/cwa_req_if.sv @@
// ---------------------------------------------------------------------------
// cwa_req_if
// Sample channel: one sample word with its end-of-stream mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface cwa_req_if;
   logic                          valid;
   logic                          ready;
   logic [cwa_pkg::SAMPLE_W-1:0]  sample;
   logic                          is_last;

   modport source (output valid, output sample, output is_last, input ready);
   modport sink   (input valid, input sample, input is_last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cwa_rsp_if.sv @@
// ---------------------------------------------------------------------------
// cwa_rsp_if
// Result channel: one average word with its end-of-stream mark.
// ---------------------------------------------------------------------------
`default_nettype none

interface cwa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [cwa_pkg::AVG_W-1:0]   average;
   logic                        last_out;

   modport source (output valid, output average, output last_out, input ready);
   modport sink   (input valid, input average, input last_out, output ready);
endinterface

`default_nettype wire

@@ rtl/core/cwa_csr_if.sv @@
// ---------------------------------------------------------------------------
// cwa_csr_if
// Register write channel carrying the radius value.
// ---------------------------------------------------------------------------
`default_nettype none

interface cwa_csr_if;
   logic                          valid;
   logic                          ready;
   logic [cwa_pkg::RADIUS_W-1:0]  data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/centered_window_average_top.sv @@
// ---------------------------------------------------------------------------
// centered_window_average_top
// Centered moving average over a sample stream, ring store in RAM.
// ---------------------------------------------------------------------------
// Usage:
//   req_port  : sample words, is_last marks the final sample of a stream.
//   rsp_port  : result words in position order; average is -1 where the
//               2k+1 window does not fit; last_out marks the final word of
//               the stream.
//   csr_port  : radius k, always ready; write only while the block is idle.
//               A write drops any stream in progress.
// Timing (one item at a time):
//   accept -> store read and running-sum update in S_SUM.
//   An average then goes through the bit-serial divider (S_DIV) and into
//   the output register.
//   Words leave at one per cycle from the output register while the receiver
//   is ready; an item with no result goes from S_SUM back to idle; the last
//   item also emits up to k trailing -1 words.
// The output register lets the next sample be accepted while a finished
// word waits; a stalled receiver holds the sequencer before its next word.
// Reset: synchronous; radius returns to 1, sum/count/slot clear. The ring
// store needs no clearing, only entries of the current stream are read.
// ---------------------------------------------------------------------------
`default_nettype none

`include "centered_window_average_top_defines.svh"

module centered_window_average_top #(
   parameter int MAX_RADIUS  = 63,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   cwa_req_if.sink    req_port,
   cwa_rsp_if.source  rsp_port,
   cwa_csr_if.sink    csr_port
);

   // widths derived from the parameters
   localparam int DATA_W = (SAMPLE_BITS < cwa_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                             : cwa_pkg::SAMPLE_W;
   localparam int CNT_W  = $clog2(2 * MAX_RADIUS + 2);  // holds 2k+1, ring address
   localparam int DEPTH  = 2 ** CNT_W;
   localparam int SUM_W  = DATA_W + CNT_W;
   localparam int RW     = cwa_pkg::RADIUS_W;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,   // ready for a sample
      S_SUM  = 4'b0010,   // old sample back from store, update sum
      S_DIV  = 4'b0100,   // average in the divider
      S_EMIT = 4'b1000    // send result words
   } state_type;

   state_type          state_ff, state_in;
   logic [RW-1:0]      radius_ff, radius_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   seen_ff, seen_in;
   logic [CNT_W-1:0]   slot_ff, slot_in;
   logic [DATA_W-1:0]  sample_ff, sample_in;
   logic               last_ff, last_in;
   logic               first_pend_ff, first_pend_in;   // lead -1 or average pending
   logic               first_avg_ff, first_avg_in;     // pending first word is an average
   logic [CNT_W-1:0]   flush_ff, flush_in;             // trailing -1 words left
   logic               rsp_valid_ff, rsp_valid_in;
   logic [cwa_pkg::AVG_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [RW-1:0]      k_wide;
   logic [CNT_W-1:0]   k;
   logic [CNT_W-1:0]   win_len;
   logic               req_take;
   logic               cfg_take;
   logic [DATA_W-1:0]  old_sample;
   logic               has_old;
   logic [SUM_W-1:0]   sum_new;                        // window sum with this sample
   logic [CNT_W-1:0]   seen_next;
   logic [CNT_W-1:0]   over_k;
   logic [CNT_W-1:0]   tail;
   logic               want_avg;
   logic               want_lead;
   logic               div_start;
   logic               div_done;
   logic [SUM_W-1:0]   div_quot;
   logic               out_free;
   logic               word_final;
   logic [cwa_pkg::AVG_W-1:0] quot_word;

   // effective radius and window length
   always_comb begin
      k_wide  = (radius_ff > RW'(MAX_RADIUS)) ? RW'(MAX_RADIUS) : radius_ff;
      k       = CNT_W'(k_wide);
      win_len = {k[CNT_W-2:0], 1'b1};
   end

   assign req_take = req_port.valid && (state_ff == S_IDLE);
   assign cfg_take = csr_port.valid;

   // ring store: new sample written on accept, oldest one read at the same time
   cwa_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (req_take),
      .wr_addr (slot_ff),
      .wr_data (req_port.sample[DATA_W-1:0]),
      .rd_addr (slot_ff - win_len),
      .rd_data (old_sample)
   );

   cwa_div #(
      .DVD_W (SUM_W),
      .DVS_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_new),
      .divisor  (win_len),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign quot_word = {{(cwa_pkg::AVG_W - DATA_W){1'b0}}, div_quot[DATA_W-1:0]};
   assign out_free  = !rsp_valid_ff || rsp_port.ready;

   always_comb begin
      state_in      = state_ff;
      radius_in     = radius_ff;
      sum_in        = sum_ff;
      seen_in       = seen_ff;
      slot_in       = slot_ff;
      sample_in     = sample_ff;
      last_in       = last_ff;
      first_pend_in = first_pend_ff;
      first_avg_in  = first_avg_ff;
      flush_in      = flush_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_avg_in    = rsp_avg_ff;
      rsp_last_in   = rsp_last_ff;
      div_start     = 1'b0;
      word_final    = 1'b0;

      // window bookkeeping for the item in S_SUM
      has_old   = (seen_ff >= win_len);
      sum_new   = sum_ff - (has_old ? {{CNT_W{1'b0}}, old_sample} : '0)
                  + {{CNT_W{1'b0}}, sample_ff};
      seen_next = has_old ? seen_ff : seen_ff + 1'b1;
      want_avg  = (seen_next >= win_len);
      want_lead = (seen_ff < k);
      over_k    = seen_next - k;
      tail      = (over_k > k) ? k : over_k;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               sample_in = req_port.sample[DATA_W-1:0];
               last_in   = req_port.is_last;
               state_in  = S_SUM;
            end
         end
         S_SUM: begin
            sum_in        = sum_new;
            first_pend_in = want_lead || want_avg;
            first_avg_in  = want_avg;
            flush_in      = (last_ff && (seen_next > k)) ? tail : '0;
            div_start     = want_avg;
            if (want_avg) begin
               state_in = S_DIV;
            end else if (want_lead || (last_ff && (seen_next > k))) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_IDLE;
            end
            if (last_ff) begin
               seen_in = '0;
               slot_in = '0;
            end else begin
               seen_in = seen_next;
               slot_in = slot_ff + 1'b1;
            end
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               if (first_pend_ff) begin
                  rsp_avg_in    = first_avg_ff ? quot_word : cwa_pkg::AVG_NONE;
                  first_pend_in = 1'b0;
                  word_final    = (flush_ff == '0);
               end else begin
                  rsp_avg_in = cwa_pkg::AVG_NONE;
                  flush_in   = flush_ff - 1'b1;
                  word_final = (flush_ff == CNT_W'(1));
               end
               rsp_valid_in = 1'b1;
               rsp_last_in  = last_ff && word_final;
               if (word_final) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // end of stream clears the running sum after it went to the divider
      if ((state_ff == S_SUM) && last_ff) begin
         sum_in = '0;
      end

      // radius write drops the stream in progress
      if (cfg_take) begin
         radius_in = csr_port.data;
         sum_in    = '0;
         seen_in   = '0;
         slot_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         radius_ff     <= cwa_pkg::RADIUS_RESET;
         sum_ff        <= '0;
         seen_ff       <= '0;
         slot_ff       <= '0;
         first_pend_ff <= 1'b0;
         flush_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         radius_ff     <= radius_in;
         sum_ff        <= sum_in;
         seen_ff       <= seen_in;
         slot_ff       <= slot_in;
         first_pend_ff <= first_pend_in;
         flush_ff      <= flush_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      sample_ff    <= sample_in;
      last_ff      <= last_in;
      first_avg_ff <= first_avg_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_port.ready    = (state_ff == S_IDLE);
   assign csr_port.ready    = 1'b1;
   assign rsp_port.valid    = rsp_valid_ff;
   assign rsp_port.average  = rsp_avg_ff;
   assign rsp_port.last_out = rsp_last_ff;

   // checks
   `CWA_ASSERT_NEXT(a_accept_to_sum, clock, reset, req_take, state_ff == S_SUM, "accepted sample did not reach sum update")
   `CWA_ASSERT_IMP(a_idle_nothing_pending, clock, reset, state_ff == S_IDLE, !first_pend_ff && (flush_ff == '0), "idle with result words still pending")
   `CWA_ASSERT_IMP(a_div_done_in_div, clock, reset, div_done, state_ff == S_DIV, "divider finished outside the divide wait")
   `CWA_ASSERT_IMP(a_count_bounded, clock, reset, 1'b1, seen_ff <= win_len, "sample count above window length")

endmodule

`default_nettype wire

@@ rtl/core/cwa_ram.sv @@
// ---------------------------------------------------------------------------
// cwa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module cwa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/core/cwa_div.sv @@
// ---------------------------------------------------------------------------
// cwa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module cwa_div #(
   parameter int DVD_W = 23,
   parameter int DVS_W = 7
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [DVD_W-1:0] dividend,
   input  wire logic [DVS_W-1:0] divisor,
   output      logic             done,
   output      logic [DVD_W-1:0] quotient
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0]  quot_ff, quot_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DVS_W:0]    partial;
   logic [DVS_W+1:0]  trial;

   always_comb begin
      partial = {rem_ff, quot_ff[DVD_W-1]};
      trial   = {1'b0, partial} - {2'b00, dvs_ff};
      quot_in = quot_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quot_in = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         step_in = STEP_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // trial subtract; sign bit set means the partial stays
         if (trial[DVS_W+1]) begin
            rem_in  = partial[DVS_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b0};
         end else begin
            rem_in  = trial[DVS_W-1:0];
            quot_in = {quot_ff[DVD_W-2:0], 1'b1};
         end
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

`default_nettype wire
